### rtl/core/pats_pkg.sv
// ----------------------------------------------------------------------------
// pats_pkg
// Types, codes and constants shared by the task scheduler core and its queue.
// ----------------------------------------------------------------------------
package pats_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [15:0] CAP_RESET = 16'd1000;
    localparam logic [8:0]  OVL_RESET = 9'd205;
    localparam logic [8:0]  OFF_RESET = 9'd179;

    typedef enum logic [1:0] {
        MODE_SUBMIT   = 2'd0,
        MODE_COMPLETE = 2'd1,
        MODE_START    = 2'd2,
        MODE_STOP     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OUT_REJECTED  = 3'd0,
        OUT_QUEUED    = 3'd1,
        OUT_OFFLOADED = 3'd2,
        OUT_COMPLETED = 3'd3,
        OUT_NO_EFFECT = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        SRV_OFFLINE    = 2'd0,
        SRV_IDLE       = 2'd1,
        SRV_PROCESSING = 2'd2,
        SRV_OVERLOADED = 2'd3
    } srv_state_t;

    typedef enum logic [1:0] {
        REG_CAPACITY = 2'd0,
        REG_OVERLOAD = 2'd1,
        REG_OFFLOAD  = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SETTLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_PULL,
        ST_SHIFT,
        ST_EMIT
    } fsm_t;

    typedef struct packed {
        logic [7:0]  priority_req;
        logic [15:0] deadline;
        logic [15:0] id;
        logic [7:0]  cluster;
        logic [15:0] size;
        logic [31:0] arrival;
    } qent_t;

endpackage

### rtl/core/pats_qmem.sv
// ----------------------------------------------------------------------------
// pats_qmem
// Queue storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pats_qmem
    import pats_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int IW = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  qent_t         wdata,
    input  logic          re,
    input  logic [IW-1:0] raddr,
    output qent_t         rdata
);

    qent_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/priority_task_admission_scheduler_core.sv
// Start, stop, rejected, offloaded and no-effect events go from evaluation straight to
// the emit state; a queued submit or a completion first settles the server state.
// An event that starts a queued task also has the queue memory scanned for the best
// entry, one read a cycle, then the entry is pulled and the queue closed up.
// One event at a time; busy stays high until done. The receiver cannot stall done.
// Reset: queue empty, server offline, ids start at 1, registers at their defaults.
// ----------------------------------------------------------------------------
// priority_task_admission_scheduler_core
// Admission control, cloud offload and priority queue service for task events.
// ----------------------------------------------------------------------------
module priority_task_admission_scheduler_core
    import pats_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  priority_req,
    input  logic [15:0] deadline,
    input  logic [15:0] request_size,
    input  logic [7:0]  source_cluster,
    input  logic        cloud_accepts,
    input  logic [31:0] now,
    output logic        done,
    output logic [2:0]  outcome,
    output logic [15:0] task_id,
    output logic [7:0]  completed_cluster,
    output logic [31:0] response_time,
    output logic        started_task,
    output logic [15:0] started_id,
    output logic [1:0]  server_state,
    output logic [4:0]  queued_count,
    output logic [15:0] current_load,
    output logic [31:0] tasks_processed,
    output logic [31:0] tasks_rejected
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0] cap_reg;
    logic [8:0]  ovl_reg;
    logic [8:0]  off_reg;
    logic [24:0] ovl_prod_reg;
    logic [24:0] off_prod_reg;

    fsm_t        state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic        busyf_reg, busyf_next;
    logic        run_reg, run_next;
    srv_state_t  srv_reg, srv_next;
    logic [15:0] act_id_reg, act_id_next;
    logic [7:0]  act_cl_reg, act_cl_next;
    logic [15:0] act_sz_reg, act_sz_next;
    logic [31:0] act_arr_reg, act_arr_next;
    logic [15:0] load_reg, load_next;
    logic [31:0] proc_reg, proc_next;
    logic [31:0] rej_reg, rej_next;
    logic [15:0] nid_reg, nid_next;

    logic [1:0]  in_mode_reg;
    qent_t       in_ent_reg;
    logic        in_cloud_reg;

    outcome_t    oc_reg, oc_next;
    logic [15:0] tid_reg, tid_next;
    logic [7:0]  ccl_reg, ccl_next;
    logic [31:0] resp_reg, resp_next;
    logic        strt_reg, strt_next;

    logic [FW-1:0] idx_reg, idx_next;
    logic        pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg;
    logic [IW-1:0] best_idx_reg;
    qent_t       best_ent_reg;

    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    qent_t       mem_wdata;
    logic        mem_re;
    logic [IW-1:0] mem_raddr;
    qent_t       mem_rdata;

    logic        done_reg;
    logic [2:0]  oc_out_reg;
    logic [15:0] tid_out_reg;
    logic [7:0]  ccl_out_reg;
    logic [31:0] resp_out_reg;
    logic        strt_out_reg;
    logic [15:0] sid_out_reg;
    logic [1:0]  srv_out_reg;
    logic [4:0]  qc_out_reg;
    logic [15:0] load_out_reg;
    logic [31:0] proc_out_reg;
    logic [31:0] rej_out_reg;

    logic        accept;
    logic        ovl_above;
    logic        off_above;
    logic        half_above;
    logic        large_task;
    logic        no_fit;
    logic        q_full;
    logic        scan_take;
    logic [31:0] fill_w;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign ovl_above  = {1'b0, load_reg, 8'h00} > ovl_prod_reg;
    assign off_above  = {1'b0, load_reg, 8'h00} > off_prod_reg;
    assign half_above = {load_reg, 1'b0} > {1'b0, cap_reg};
    assign large_task = in_ent_reg.size > {2'b00, cap_reg[15:2]};
    assign no_fit     = ({1'b0, load_reg} + {1'b0, in_ent_reg.size}) > {1'b0, cap_reg};
    assign q_full     = fill_reg >= FW'(QUEUE_DEPTH);
    assign scan_take  = pend_reg && ((state_reg == ST_SCAN) || (state_reg == ST_SCAN_LAST))
                        && ((pend_idx_reg == '0) ||
                            ({mem_rdata.priority_req, mem_rdata.deadline} <
                             {best_ent_reg.priority_req, best_ent_reg.deadline}));
    assign fill_w     = 32'(fill_reg);

    pats_qmem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_qmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            ovl_reg <= OVL_RESET;
            off_reg <= OFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CAPACITY: cap_reg <= cfg_data;
                REG_OVERLOAD: ovl_reg <= cfg_data[8:0];
                REG_OFFLOAD:  off_reg <= cfg_data[8:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ovl_prod_reg <= 25'(ovl_reg) * 25'(cap_reg);
        off_prod_reg <= 25'(off_reg) * 25'(cap_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            busyf_reg <= 1'b0;
            run_reg   <= 1'b0;
            srv_reg   <= SRV_OFFLINE;
            act_id_reg  <= '0;
            act_cl_reg  <= '0;
            act_sz_reg  <= '0;
            act_arr_reg <= '0;
            load_reg  <= '0;
            proc_reg  <= '0;
            rej_reg   <= '0;
            nid_reg   <= 16'd1;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            busyf_reg <= busyf_next;
            run_reg   <= run_next;
            srv_reg   <= srv_next;
            act_id_reg  <= act_id_next;
            act_cl_reg  <= act_cl_next;
            act_sz_reg  <= act_sz_next;
            act_arr_reg <= act_arr_next;
            load_reg  <= load_next;
            proc_reg  <= proc_next;
            rej_reg   <= rej_next;
            nid_reg   <= nid_next;
            pend_reg  <= pend_next;
            done_reg  <= (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_mode_reg  <= mode;
            in_cloud_reg <= cloud_accepts;
            in_ent_reg   <= '{priority_req: priority_req, deadline: deadline,
                              id: 16'd0, cluster: source_cluster,
                              size: request_size, arrival: now};
        end
        oc_reg   <= oc_next;
        tid_reg  <= tid_next;
        ccl_reg  <= ccl_next;
        resp_reg <= resp_next;
        strt_reg <= strt_next;
        idx_reg  <= idx_next;
        pend_idx_reg <= idx_reg[IW-1:0];
        if (scan_take)
        begin
            best_idx_reg <= pend_idx_reg;
            best_ent_reg <= mem_rdata;
        end
        if (state_reg == ST_EMIT)
        begin
            oc_out_reg   <= oc_reg;
            tid_out_reg  <= tid_reg;
            ccl_out_reg  <= ccl_reg;
            resp_out_reg <= resp_reg;
            strt_out_reg <= strt_reg;
            sid_out_reg  <= strt_reg ? act_id_reg : 16'd0;
            srv_out_reg  <= srv_reg;
            qc_out_reg   <= fill_w[4:0];
            load_out_reg <= load_reg;
            proc_out_reg <= proc_reg;
            rej_out_reg  <= rej_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        busyf_next = busyf_reg;
        run_next   = run_reg;
        srv_next   = srv_reg;
        act_id_next  = act_id_reg;
        act_cl_next  = act_cl_reg;
        act_sz_next  = act_sz_reg;
        act_arr_next = act_arr_reg;
        load_next  = load_reg;
        proc_next  = proc_reg;
        rej_next   = rej_reg;
        nid_next   = nid_reg;
        oc_next    = oc_reg;
        tid_next   = tid_reg;
        ccl_next   = ccl_reg;
        resp_next  = resp_reg;
        strt_next  = strt_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = pend_idx_reg - IW'(1);
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                oc_next   = OUT_NO_EFFECT;
                tid_next  = '0;
                ccl_next  = '0;
                resp_next = '0;
                strt_next = 1'b0;
                state_next = ST_EMIT;
                unique case (mode_t'(in_mode_reg))
                    MODE_SUBMIT:
                    begin
                        if (!run_reg || (srv_reg == SRV_OFFLINE))
                        begin
                            oc_next = OUT_REJECTED;
                        end
                        else if ((off_above || (half_above && large_task)) && in_cloud_reg)
                        begin
                            oc_next = OUT_OFFLOADED;
                        end
                        else if (no_fit || q_full)
                        begin
                            oc_next = OUT_REJECTED;
                        end
                        else
                        begin
                            oc_next   = OUT_QUEUED;
                            tid_next  = nid_reg;
                            nid_next  = (nid_reg == 16'hFFFF) ? 16'd1 : nid_reg + 16'd1;
                            mem_we    = 1'b1;
                            mem_waddr = fill_reg[IW-1:0];
                            mem_wdata = in_ent_reg;
                            mem_wdata.id = nid_reg;
                            fill_next = fill_reg + FW'(1);
                            load_next = load_reg + in_ent_reg.size;
                            state_next = ST_SETTLE;
                        end
                        if ((oc_next == OUT_REJECTED) && (rej_reg != 32'hFFFF_FFFF))
                        begin
                            rej_next = rej_reg + 32'd1;
                        end
                    end
                    MODE_COMPLETE:
                    begin
                        if (busyf_reg)
                        begin
                            oc_next   = OUT_COMPLETED;
                            tid_next  = act_id_reg;
                            ccl_next  = act_cl_reg;
                            resp_next = in_ent_reg.arrival - act_arr_reg;
                            if (proc_reg != 32'hFFFF_FFFF)
                            begin
                                proc_next = proc_reg + 32'd1;
                            end
                            load_next  = (load_reg >= act_sz_reg) ? load_reg - act_sz_reg : '0;
                            busyf_next = 1'b0;
                            state_next = ST_SETTLE;
                        end
                    end
                    MODE_START:
                    begin
                        if (!run_reg)
                        begin
                            run_next   = 1'b1;
                            fill_next  = '0;
                            load_next  = '0;
                            busyf_next = 1'b0;
                            srv_next   = SRV_IDLE;
                        end
                    end
                    MODE_STOP:
                    begin
                        if (run_reg)
                        begin
                            run_next   = 1'b0;
                            fill_next  = '0;
                            load_next  = '0;
                            busyf_next = 1'b0;
                            srv_next   = SRV_OFFLINE;
                        end
                    end
                    default: ;
                endcase
            end

            ST_SETTLE:
            begin
                if (ovl_above)
                begin
                    srv_next = SRV_OVERLOADED;
                end
                else if (busyf_reg || (fill_reg != '0))
                begin
                    srv_next = SRV_PROCESSING;
                end
                else
                begin
                    srv_next = SRV_IDLE;
                end
                if (run_reg && (fill_reg != '0) && !busyf_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_SCAN:
            begin
                mem_re    = 1'b1;
                pend_next = 1'b1;
                idx_next  = idx_reg + FW'(1);
                if (idx_reg == fill_reg - FW'(1))
                begin
                    state_next = ST_SCAN_LAST;
                end
            end

            ST_SCAN_LAST:
            begin
                state_next = ST_PULL;
            end

            ST_PULL:
            begin
                act_id_next  = best_ent_reg.id;
                act_cl_next  = best_ent_reg.cluster;
                act_sz_next  = best_ent_reg.size;
                act_arr_next = best_ent_reg.arrival;
                idx_next     = FW'(best_idx_reg) + FW'(1);
                state_next   = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                mem_we = pend_reg;
                if (idx_reg < fill_reg)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + FW'(1);
                end
                else if (!pend_reg)
                begin
                    fill_next  = fill_reg - FW'(1);
                    busyf_next = 1'b1;
                    strt_next  = 1'b1;
                    state_next = ST_SETTLE;
                end
            end

            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done              = done_reg;
    assign outcome           = oc_out_reg;
    assign task_id           = tid_out_reg;
    assign completed_cluster = ccl_out_reg;
    assign response_time     = resp_out_reg;
    assign started_task      = strt_out_reg;
    assign started_id        = sid_out_reg;
    assign server_state      = srv_out_reg;
    assign queued_count      = qc_out_reg;
    assign current_load      = load_out_reg;
    assign tasks_processed   = proc_out_reg;
    assign tasks_rejected    = rej_out_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_pull_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PULL) |-> (run_reg && !busyf_reg && (fill_reg != '0)))
        else $error("queue pull without a runnable queue");
`endif

endmodule
